FILE: hdl/mvng_pkg.sv
// mvng_pkg: shared constants, payload structs and state encodings of the vertex normal generator
package mvng_pkg;

    localparam int MAX_VERTS    = 64;
    localparam int VIDX_W       = $clog2(MAX_VERTS);
    localparam int CNT_W        = VIDX_W + 1;
    localparam int COORD_W      = 16;
    localparam int NRM_W        = 16;
    localparam int ACC_W        = 42;
    localparam int OPND_W       = 18;
    localparam int PROD_W       = 2 * OPND_W;
    localparam int ONE_Q14      = 16384;
    localparam int WELD_DIVISOR = 10000;
    localparam int DEGEN_LSB    = 1;
    localparam int TOL_MAX      = (3 * 65535) / WELD_DIVISOR;
    localparam int TOL_W        = $clog2(TOL_MAX + 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      end_of_polygon;
        logic                      end_of_mesh;
    } in_item_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic                    last;
        logic                    overflow;
    } out_item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] z;
    } acc_vec_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] z;
    } nrm_vec_t;

    typedef enum logic [1:0] {
        CFG_IS_CCW = 2'd0,
        CFG_FLAT   = 2'd1,
        CFG_CREASE = 2'd2
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE, S_CHK,
        S_CL_RD0, S_CL_P0, S_CL_B, S_CL_MUL, S_CL_NORM, S_CL_WAIT, S_CL_WR,
        S_MESH,
        S_WD_RDI, S_WD_I, S_WD_CMP, S_WD_RR, S_WD_RW, S_WD_NEXT,
        S_EM_RD, S_EM_F, S_EM_G, S_EM_DOT, S_EM_ADD, S_EM_NORM, S_EM_WAIT, S_EM_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DIVI, N_DIV, N_DONE
    } norm_state_t;

endpackage

FILE: hdl/mvng_norm.sv
// mvng_norm: multi-cycle vector normaliser (shift, square sum, bitwise root, restoring divide)
module mvng_norm
    import mvng_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  acc_vec_t vin,
    output logic     done,
    output nrm_vec_t vout
);

    norm_state_t state_reg, state_next;

    logic [ACC_W-1:0]       a_reg [3];
    logic                   neg_reg [3];
    logic [ACC_W-1:0]       m_reg;
    logic [63:0]            q_reg;
    logic [59:0]            sq_reg;
    logic [63:0]            bit_reg;
    logic [63:0]            root_reg;
    logic [32:0]            rem_reg;
    logic [15:0]            nlo_reg;
    logic [15:0]            quo_reg;
    logic [4:0]             cnt_reg;
    logic [1:0]             k_reg;
    logic signed [NRM_W-1:0] out_reg [3];

    logic signed [ACC_W-1:0] vin_c [3];
    logic [ACC_W-1:0]        abs_c [3];
    logic [ACC_W-1:0]        max_c;
    logic [29:0]             sq_in;
    logic [29:0]             div_a;
    logic [63:0]             trial;
    logic [30:0]             r_c;
    logic [44:0]             num_c;
    logic [32:0]             rem_sh;
    logic                    q_bit;
    logic [15:0]             quo_n;
    logic [15:0]             cap_c;

    assign vin_c[0] = vin.x;
    assign vin_c[1] = vin.y;
    assign vin_c[2] = vin.z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            abs_c[k] = vin_c[k][ACC_W-1] ? ACC_W'(-vin_c[k]) : ACC_W'(vin_c[k]);
        end
        max_c = abs_c[0];
        if (abs_c[1] > max_c)
        begin
            max_c = abs_c[1];
        end
        if (abs_c[2] > max_c)
        begin
            max_c = abs_c[2];
        end
    end

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    sq_in = a_reg[0][29:0];
            2'd1:    sq_in = a_reg[1][29:0];
            default: sq_in = a_reg[2][29:0];
        endcase
        case (k_reg)
            2'd0:    div_a = a_reg[0][29:0];
            2'd1:    div_a = a_reg[1][29:0];
            default: div_a = a_reg[2][29:0];
        endcase
        trial  = root_reg + bit_reg;
        r_c    = root_reg[30:0];
        num_c  = {1'b0, div_a, 14'b0} + 45'(r_c >> 1);
        rem_sh = {rem_reg[31:0], nlo_reg[15]};
        q_bit  = rem_sh >= 33'(r_c);
        quo_n  = {quo_reg[14:0], q_bit};
        cap_c  = (quo_n > 16'(ONE_Q14)) ? 16'(ONE_Q14) : quo_n;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE:  if (start) state_next = (max_c == '0) ? N_DONE : N_SHIFT;
            N_SHIFT: if (m_reg[ACC_W-1:30] == '0 && m_reg[29]) state_next = N_SQ;
            N_SQ:    if (cnt_reg == 5'd3) state_next = N_SQRT;
            N_SQRT:  if (cnt_reg == 5'd31) state_next = N_DIVI;
            N_DIVI:  state_next = N_DIV;
            N_DIV:
            begin
                if (cnt_reg == 5'd15)
                begin
                    state_next = (k_reg == 2'd2) ? N_DONE : N_DIVI;
                end
            end
            N_DONE:  state_next = N_IDLE;
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                N_SHIFT: cnt_reg <= '0;
                N_SQ:    cnt_reg <= (cnt_reg == 5'd3) ? 5'd0 : cnt_reg + 5'd1;
                N_SQRT:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    k_reg   <= '0;
                end
                N_DIVI:  cnt_reg <= '0;
                N_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15)
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        a_reg[k]   <= abs_c[k];
                        neg_reg[k] <= vin_c[k][ACC_W-1];
                        out_reg[k] <= '0;
                    end
                    m_reg <= max_c;
                end
            end
            N_SHIFT:
            begin
                if (m_reg[ACC_W-1:30] != '0)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        a_reg[k] <= a_reg[k] >> 1;
                    end
                    m_reg <= m_reg >> 1;
                end
                else if (!m_reg[29])
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        a_reg[k] <= a_reg[k] << 1;
                    end
                    m_reg <= m_reg << 1;
                end
                q_reg <= '0;
            end
            N_SQ:
            begin
                sq_reg <= sq_in * sq_in;
                if (cnt_reg != 5'd0)
                begin
                    q_reg <= q_reg + 64'(sq_reg);
                end
                bit_reg  <= 64'd1 << 62;
                root_reg <= '0;
            end
            N_SQRT:
            begin
                if (q_reg >= trial)
                begin
                    q_reg    <= q_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            N_DIVI:
            begin
                rem_reg <= 33'(num_c[44:16]);
                nlo_reg <= num_c[15:0];
                quo_reg <= '0;
            end
            N_DIV:
            begin
                rem_reg <= q_bit ? rem_sh - 33'(r_c) : rem_sh;
                nlo_reg <= nlo_reg << 1;
                quo_reg <= quo_n;
                if (cnt_reg == 5'd15)
                begin
                    out_reg[k_reg] <= neg_reg[k_reg] ? -$signed(cap_c) : $signed(cap_c);
                end
            end
            default: ;
        endcase
    end

    assign done   = (state_reg == N_DONE);
    assign vout.x = out_reg[0];
    assign vout.y = out_reg[1];
    assign vout.z = out_reg[2];

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == N_IDLE)
        else $error("normaliser started while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("normaliser done held");
    a_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == N_DIV |-> root_reg[30:29] != 2'b00)
        else $error("root out of range during divide");

endmodule

FILE: hdl/mesh_vertex_normal_generator.sv
// mesh_vertex_normal_generator: top level with vertex, face normal and weld ring stores and sequencer
//
// vertices arrive one beat at a time (start while busy is low) and are stored up to 64 per
// mesh; further vertices are dropped and flagged. a beat that neither closes a polygon nor the
// mesh leaves the block idle. closing a polygon runs the newell sum through the
// single 18x18 multiplier, then the shared normaliser (bit-serial shift, three squares, 32-step
// root, three 16-step divides), then one face normal write per vertex. end of mesh, unless
// flat is set, welds vertices by comparing each one against earlier ones, latest first, up to
// the first match (one compare a cycle), then produces one result per stored vertex: a dot
// product per ring peer and one normaliser pass, or in flat mode the stored face normal. each
// result is shown for exactly one cycle on result with result_strobe high; the receiver cannot
// stall, so results must be taken as they come. busy stays high from the closing beat until the
// face normals are written or, at end of mesh, the last result. configuration writes are always
// accepted (cfg_ready is high) and must only be made while the block is idle.
module mesh_vertex_normal_generator
    import mvng_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        result_strobe,
    output out_item_t   result
);

    top_state_t state_reg, state_next;

    // control state
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          pstart_reg;
    logic                      dropped_reg;
    logic signed [COORD_W-1:0] bmin_reg [3];
    logic signed [COORD_W-1:0] bmax_reg [3];
    logic                      eom_reg;
    logic                      ccw_reg;
    logic                      flat_reg;
    logic signed [15:0]        crease_reg;
    logic                      strobe_reg;
    logic [CNT_W-1:0]          i_reg;
    logic [VIDX_W-1:0]         j_reg;
    logic [2:0]                mstep_reg;
    logic [CNT_W-1:0]          steps_reg;

    // datapath
    logic signed [COORD_W-1:0] p0_reg [3];
    logic signed [OPND_W-1:0]  a_reg [3];
    logic signed [OPND_W-1:0]  b_reg [3];
    logic signed [ACC_W-1:0]   s_reg [3];
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  dot_reg;
    logic signed [COORD_W-1:0] vi_reg [3];
    logic signed [NRM_W-1:0]   f_reg [3];
    logic signed [NRM_W-1:0]   g_reg [3];
    logic [VIDX_W-1:0]         jn_reg;
    logic [TOL_W-1:0]          tol_reg;
    logic                      degen_reg;
    nrm_vec_t                  fnorm_reg;
    nrm_vec_t                  res_reg;
    out_item_t                 result_reg;

    // stores
    logic [3*COORD_W-1:0] vmem [MAX_VERTS];
    logic [3*NRM_W-1:0]   fmem [MAX_VERTS];
    logic [VIDX_W-1:0]    rmem [MAX_VERTS];
    logic [3*COORD_W-1:0] vrd_reg;
    logic [3*NRM_W-1:0]   frd_reg;
    logic [VIDX_W-1:0]    rrd_reg;

    logic [VIDX_W-1:0]    vaddr, faddr, raddr, rwaddr, rwdata;
    logic                 rwe;
    logic                 norm_start, norm_done;
    acc_vec_t             norm_in;
    nrm_vec_t             norm_out;

    logic                      accept;
    logic                      store_ok;
    logic signed [COORD_W-1:0] in_c [3];
    logic signed [COORD_W-1:0] vrd_c [3];
    logic signed [NRM_W-1:0]   frd_c [3];
    logic signed [OPND_W-1:0]  mul_a, mul_b;
    logic [17:0]               extent_c;
    logic [TOL_W-1:0]          tol_c;
    logic                      match_c;
    logic                      smooth_c;
    logic signed [PROD_W-1:0]  thr_c;
    logic                      degen_c;
    logic [2:0]                mt;

    function automatic logic [VIDX_W-1:0] pb_addr(input logic [CNT_W-1:0] e,
                                                  input logic [CNT_W-1:0] ps,
                                                  input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] nn;
        logic [CNT_W-1:0] jj;
        logic [CNT_W-1:0] sm;
        nn = cnt - ps;
        jj = (e + CNT_W'(1) == nn) ? '0 : e + CNT_W'(1);
        sm = ps + jj;
        return sm[VIDX_W-1:0];
    endfunction

    function automatic logic near(input logic signed [COORD_W-1:0] a,
                                  input logic signed [COORD_W-1:0] b,
                                  input logic [TOL_W-1:0] tol);
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        ad;
        d  = (COORD_W+1)'(a) - (COORD_W+1)'(b);
        ad = d[COORD_W] ? (COORD_W+1)'(-d) : (COORD_W+1)'(d);
        return ad <= (COORD_W+1)'(tol);
    endfunction

    // newell cross-term order: a1b2, a2b1, a2b0, a0b2, a0b1, a1b0
    function automatic logic [1:0] nw_a(input logic [2:0] m);
        case (m)
            3'd0, 3'd5: return 2'd1;
            3'd1, 3'd2: return 2'd2;
            default:    return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] nw_b(input logic [2:0] m);
        case (m)
            3'd0, 3'd3: return 2'd2;
            3'd1, 3'd4: return 2'd1;
            default:    return 2'd0;
        endcase
    endfunction

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign store_ok  = count_reg < CNT_W'(MAX_VERTS);

    assign in_c[0]  = item.x;
    assign in_c[1]  = item.y;
    assign in_c[2]  = item.z;
    assign vrd_c[0] = vrd_reg[47:32];
    assign vrd_c[1] = vrd_reg[31:16];
    assign vrd_c[2] = vrd_reg[15:0];
    assign frd_c[0] = frd_reg[47:32];
    assign frd_c[1] = frd_reg[31:16];
    assign frd_c[2] = frd_reg[15:0];

    // weld tolerance: largest t with t*10000 <= extent sum
    always_comb
    begin
        extent_c = '0;
        for (int k = 0; k < 3; k++)
        begin
            extent_c = extent_c + 18'(17'(bmax_reg[k]) - 17'(bmin_reg[k]));
        end
        tol_c = '0;
        for (int t = 1; t <= TOL_MAX; t++)
        begin
            if (extent_c >= 18'(t * WELD_DIVISOR))
            begin
                tol_c = TOL_W'(t);
            end
        end
    end

    assign match_c = near(vrd_c[0], vi_reg[0], tol_reg) && near(vrd_c[1], vi_reg[1], tol_reg)
                     && near(vrd_c[2], vi_reg[2], tol_reg);
    assign thr_c    = $signed({{(PROD_W-30){crease_reg[15]}}, crease_reg, 14'b0});
    assign smooth_c = degen_reg || (dot_reg > thr_c);

    always_comb
    begin
        degen_c = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            if (frd_c[k] > NRM_W'(DEGEN_LSB) || frd_c[k] < -NRM_W'(DEGEN_LSB))
            begin
                degen_c = 1'b0;
            end
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_CL_MUL)
        begin
            mul_a = a_reg[nw_a(mstep_reg)];
            mul_b = b_reg[nw_b(mstep_reg)];
        end
        else if (state_reg == S_EM_DOT)
        begin
            case (mstep_reg)
                3'd0:
                begin
                    mul_a = OPND_W'(f_reg[0]);
                    mul_b = OPND_W'(g_reg[0]);
                end
                3'd1:
                begin
                    mul_a = OPND_W'(f_reg[1]);
                    mul_b = OPND_W'(g_reg[1]);
                end
                3'd2:
                begin
                    mul_a = OPND_W'(f_reg[2]);
                    mul_b = OPND_W'(g_reg[2]);
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        norm_in.x = s_reg[0];
        norm_in.y = s_reg[1];
        norm_in.z = s_reg[2];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        vaddr      = '0;
        faddr      = '0;
        raddr      = '0;
        rwe        = 1'b0;
        rwaddr     = '0;
        rwdata     = '0;
        norm_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.end_of_polygon || item.end_of_mesh))
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (count_reg > pstart_reg)
                begin
                    state_next = S_CL_RD0;
                end
                else
                begin
                    state_next = eom_reg ? S_MESH : S_IDLE;
                end
            end
            S_CL_RD0:
            begin
                vaddr      = pstart_reg[VIDX_W-1:0];
                state_next = S_CL_P0;
            end
            S_CL_P0:
            begin
                vaddr      = pb_addr('0, pstart_reg, count_reg);
                state_next = S_CL_B;
            end
            S_CL_B:
            begin
                state_next = S_CL_MUL;
            end
            S_CL_MUL:
            begin
                if (mstep_reg == 3'd6)
                begin
                    if (i_reg + CNT_W'(1) == count_reg - pstart_reg)
                    begin
                        state_next = S_CL_NORM;
                    end
                    else
                    begin
                        vaddr      = pb_addr(i_reg + CNT_W'(1), pstart_reg, count_reg);
                        state_next = S_CL_B;
                    end
                end
            end
            S_CL_NORM:
            begin
                norm_start = 1'b1;
                state_next = S_CL_WAIT;
            end
            S_CL_WAIT:
            begin
                if (norm_done)
                begin
                    state_next = S_CL_WR;
                end
            end
            S_CL_WR:
            begin
                if (i_reg + CNT_W'(1) == count_reg)
                begin
                    state_next = eom_reg ? S_MESH : S_IDLE;
                end
            end
            S_MESH:
            begin
                if (count_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = flat_reg ? S_EM_RD : S_WD_RDI;
                end
            end
            S_WD_RDI:
            begin
                vaddr      = i_reg[VIDX_W-1:0];
                state_next = S_WD_I;
            end
            S_WD_I:
            begin
                rwe    = 1'b1;
                rwaddr = i_reg[VIDX_W-1:0];
                rwdata = i_reg[VIDX_W-1:0];
                if (i_reg == '0)
                begin
                    state_next = S_WD_NEXT;
                end
                else
                begin
                    vaddr      = i_reg[VIDX_W-1:0] - VIDX_W'(1);
                    state_next = S_WD_CMP;
                end
            end
            S_WD_CMP:
            begin
                if (match_c)
                begin
                    raddr      = j_reg - VIDX_W'(1);
                    state_next = S_WD_RR;
                end
                else if (j_reg == VIDX_W'(1))
                begin
                    state_next = S_WD_NEXT;
                end
                else
                begin
                    vaddr = j_reg - VIDX_W'(2);
                end
            end
            S_WD_RR:
            begin
                rwe        = 1'b1;
                rwaddr     = i_reg[VIDX_W-1:0];
                rwdata     = rrd_reg;
                state_next = S_WD_RW;
            end
            S_WD_RW:
            begin
                rwe        = 1'b1;
                rwaddr     = j_reg - VIDX_W'(1);
                rwdata     = i_reg[VIDX_W-1:0];
                state_next = S_WD_NEXT;
            end
            S_WD_NEXT:
            begin
                state_next = (i_reg + CNT_W'(1) == count_reg) ? S_EM_RD : S_WD_RDI;
            end
            S_EM_RD:
            begin
                faddr      = i_reg[VIDX_W-1:0];
                raddr      = i_reg[VIDX_W-1:0];
                state_next = S_EM_F;
            end
            S_EM_F:
            begin
                if (flat_reg)
                begin
                    state_next = S_EM_OUT;
                end
                else if (rrd_reg == i_reg[VIDX_W-1:0])
                begin
                    state_next = S_EM_NORM;
                end
                else
                begin
                    faddr      = rrd_reg;
                    raddr      = rrd_reg;
                    state_next = S_EM_G;
                end
            end
            S_EM_G:
            begin
                state_next = S_EM_DOT;
            end
            S_EM_DOT:
            begin
                if (mstep_reg == 3'd3)
                begin
                    state_next = S_EM_ADD;
                end
            end
            S_EM_ADD:
            begin
                if (jn_reg != i_reg[VIDX_W-1:0] && steps_reg + CNT_W'(1) < count_reg)
                begin
                    faddr      = jn_reg;
                    raddr      = jn_reg;
                    state_next = S_EM_G;
                end
                else
                begin
                    state_next = S_EM_NORM;
                end
            end
            S_EM_NORM:
            begin
                norm_start = 1'b1;
                state_next = S_EM_WAIT;
            end
            S_EM_WAIT:
            begin
                if (norm_done)
                begin
                    state_next = S_EM_OUT;
                end
            end
            S_EM_OUT:
            begin
                state_next = (i_reg + CNT_W'(1) == count_reg) ? S_IDLE : S_EM_RD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pstart_reg  <= '0;
            dropped_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                bmin_reg[k] <= 16'sh7fff;
                bmax_reg[k] <= 16'sh8000;
            end
            eom_reg     <= 1'b0;
            ccw_reg     <= 1'b1;
            flat_reg    <= 1'b0;
            crease_reg  <= 16'sd14379;
            strobe_reg  <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            mstep_reg   <= '0;
            steps_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_IS_CCW: ccw_reg    <= cfg_data[0];
                    CFG_FLAT:   flat_reg   <= cfg_data[0];
                    CFG_CREASE: crease_reg <= cfg_data;
                    default:    ;
                endcase
            end
            state_reg  <= state_next;
            strobe_reg <= (state_reg == S_EM_OUT);
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        eom_reg <= item.end_of_mesh;
                        if (store_ok)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                            for (int k = 0; k < 3; k++)
                            begin
                                if (in_c[k] < bmin_reg[k]) bmin_reg[k] <= in_c[k];
                                if (in_c[k] > bmax_reg[k]) bmax_reg[k] <= in_c[k];
                            end
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                    end
                end
                S_CL_P0:   i_reg <= '0;
                S_CL_B:    mstep_reg <= '0;
                S_CL_MUL:
                begin
                    mstep_reg <= mstep_reg + 3'd1;
                    if (mstep_reg == 3'd6)
                    begin
                        i_reg <= i_reg + CNT_W'(1);
                    end
                end
                S_CL_WAIT: if (norm_done) i_reg <= pstart_reg;
                S_CL_WR:
                begin
                    i_reg <= i_reg + CNT_W'(1);
                    if (i_reg + CNT_W'(1) == count_reg)
                    begin
                        pstart_reg <= count_reg;
                    end
                end
                S_MESH:
                begin
                    i_reg <= '0;
                    if (count_reg == '0)
                    begin
                        pstart_reg  <= '0;
                        dropped_reg <= 1'b0;
                        for (int k = 0; k < 3; k++)
                        begin
                            bmin_reg[k] <= 16'sh7fff;
                            bmax_reg[k] <= 16'sh8000;
                        end
                    end
                end
                S_WD_I:    j_reg <= i_reg[VIDX_W-1:0];
                S_WD_CMP:  if (!match_c) j_reg <= j_reg - VIDX_W'(1);
                S_WD_NEXT: i_reg <= (i_reg + CNT_W'(1) == count_reg) ? '0 : i_reg + CNT_W'(1);
                S_EM_F:
                begin
                    steps_reg <= '0;
                    j_reg     <= rrd_reg;
                end
                S_EM_G:    mstep_reg <= '0;
                S_EM_DOT:  mstep_reg <= mstep_reg + 3'd1;
                S_EM_ADD:
                begin
                    j_reg     <= jn_reg;
                    steps_reg <= steps_reg + CNT_W'(1);
                end
                S_EM_OUT:
                begin
                    i_reg <= i_reg + CNT_W'(1);
                    if (i_reg + CNT_W'(1) == count_reg)
                    begin
                        count_reg   <= '0;
                        pstart_reg  <= '0;
                        dropped_reg <= 1'b0;
                        for (int k = 0; k < 3; k++)
                        begin
                            bmin_reg[k] <= 16'sh7fff;
                            bmax_reg[k] <= 16'sh8000;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    assign mt = mstep_reg - 3'd1;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_CL_P0:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    p0_reg[k] <= vrd_c[k];
                    a_reg[k]  <= '0;
                    s_reg[k]  <= '0;
                end
            end
            S_CL_B:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    b_reg[k] <= OPND_W'(vrd_c[k]) - OPND_W'(p0_reg[k]);
                end
            end
            S_CL_MUL:
            begin
                if (mstep_reg != 3'd0)
                begin
                    if (mt[0])
                    begin
                        s_reg[mt[2:1]] <= s_reg[mt[2:1]] - ACC_W'(prod_reg);
                    end
                    else
                    begin
                        s_reg[mt[2:1]] <= s_reg[mt[2:1]] + ACC_W'(prod_reg);
                    end
                end
                if (mstep_reg == 3'd6)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        a_reg[k] <= b_reg[k];
                    end
                end
            end
            S_CL_WAIT:
            begin
                if (norm_done)
                begin
                    fnorm_reg.x <= ccw_reg ? norm_out.x : -norm_out.x;
                    fnorm_reg.y <= ccw_reg ? norm_out.y : -norm_out.y;
                    fnorm_reg.z <= ccw_reg ? norm_out.z : -norm_out.z;
                end
            end
            S_MESH:    tol_reg <= tol_c;
            S_WD_I:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    vi_reg[k] <= vrd_c[k];
                end
            end
            S_EM_F:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    f_reg[k] <= frd_c[k];
                    s_reg[k] <= ACC_W'(frd_c[k]);
                end
                degen_reg <= degen_c;
                res_reg   <= frd_reg;
            end
            S_EM_G:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    g_reg[k] <= frd_c[k];
                end
                jn_reg  <= rrd_reg;
                dot_reg <= '0;
            end
            S_EM_DOT:  if (mstep_reg != 3'd0) dot_reg <= dot_reg + prod_reg;
            S_EM_ADD:
            begin
                if (smooth_c)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        s_reg[k] <= s_reg[k] + ACC_W'(g_reg[k]);
                    end
                end
            end
            S_EM_WAIT: if (norm_done) res_reg <= norm_out;
            S_EM_OUT:
            begin
                result_reg.nx       <= res_reg.x;
                result_reg.ny       <= res_reg.y;
                result_reg.nz       <= res_reg.z;
                result_reg.last     <= (i_reg + CNT_W'(1) == count_reg);
                result_reg.overflow <= dropped_reg;
            end
            default: ;
        endcase
    end

    // stores, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (accept && store_ok)
        begin
            vmem[count_reg[VIDX_W-1:0]] <= {item.x, item.y, item.z};
        end
        vrd_reg <= vmem[vaddr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CL_WR)
        begin
            fmem[i_reg[VIDX_W-1:0]] <= fnorm_reg;
        end
        frd_reg <= fmem[faddr];
    end

    always_ff @(posedge clk)
    begin
        if (rwe)
        begin
            rmem[rwaddr] <= rwdata;
        end
        rrd_reg <= rmem[raddr];
    end

    mvng_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .vin   (norm_in),
        .done  (norm_done),
        .vout  (norm_out)
    );

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(state_reg == S_EM_OUT))
        else $error("result beat without an output step");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_VERTS) && pstart_reg <= count_reg)
        else $error("vertex count out of range");
    a_norm_wait: assert property (@(posedge clk) disable iff (!rst_n)
        norm_start |=> (state_reg == S_CL_WAIT || state_reg == S_EM_WAIT))
        else $error("normaliser launched outside a wait step");
    a_mesh_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |-> count_reg == '0)
        else $error("mesh not cleared after last beat");

endmodule
